// File: src/direct_dft_bin_engine_top_defines.svh
// Assertion macros used by the DFT bin engine checker.
`ifndef DIRECT_DFT_BIN_ENGINE_TOP_DEFINES_SVH
`define DIRECT_DFT_BIN_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication.
`define DDBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DDBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ddbe_pkg.sv
// Shared types, constants and twiddle table builders of the DFT bin engine.
package ddbe_pkg;

    localparam int TW_LOG2  = 12;
    localparam int OCT_SIZE = 512;
    localparam int PIPE_LAT = 4;

    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam logic [63:0] ONE_Q30       = 64'd1 << 30;
    localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BIN   = 1'b1;

    localparam logic [2:0] CFG_INVERSE      = 3'd0;
    localparam logic [2:0] CFG_SIZE_LOG2    = 3'd1;
    localparam logic [2:0] CFG_SCALE_BY_N   = 3'd2;
    localparam logic [2:0] CFG_SAMPLES_USED = 3'd3;

    typedef logic [30:0] t_oct_tab [0:OCT_SIZE];

    typedef struct packed {
        logic        valid;
        logic [11:0] phase;
    } t_tw_req;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_tw_rsp;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] xr;
        logic signed [15:0] xi;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_mac_in;

    typedef struct packed {
        logic       valid;
        logic       by_n;
        logic [3:0] lg;
    } t_scl_ctl;

    typedef struct packed {
        logic        valid;
        logic [15:0] value;
        logic        sat;
    } t_scl_rsp;

    // First-octant sine, Q1.30, Taylor series to x^11 in Horner form.
    function automatic t_oct_tab oct_sin_tab();
        t_oct_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int u = 0; u <= OCT_SIZE; u++) begin
            x  = (PI_Q30 * 64'(u) + 64'd1024) >> 11;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            tab[u] = 31'((x * t) >> 30);
        end
        return tab;
    endfunction

    // First-octant cosine, Q1.30, Taylor series to x^12 in Horner form.
    function automatic t_oct_tab oct_cos_tab();
        t_oct_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int u = 0; u <= OCT_SIZE; u++) begin
            x  = (PI_Q30 * 64'(u) + 64'd1024) >> 11;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd132;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd90;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd56;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd2;
            tab[u] = 31'(t);
        end
        return tab;
    endfunction

endpackage

// File: src/ddbe_twiddle.sv
// Twiddle generator: octant ROMs plus quadrant and direction unfolding.
module ddbe_twiddle
    import ddbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_inverse,
    input  t_tw_req i_req,
    output t_tw_rsp o_rsp
);

    localparam t_oct_tab SIN_TAB = oct_sin_tab();
    localparam t_oct_tab COS_TAB = oct_cos_tab();

    logic [9:0]         rem;
    logic [9:0]         rom_addr;
    logic [30:0]        r_sin;
    logic [30:0]        r_cos;
    logic [1:0]         r_quad;
    logic               r_swap;
    logic               r_rd_valid;
    logic signed [31:0] sv;
    logic signed [31:0] cv;
    logic signed [31:0] s_mag;
    logic signed [31:0] c_mag;
    logic               s_neg;
    logic               c_neg;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic               r_tw_valid;

    assign rem      = i_req.phase[9:0];
    assign rom_addr = (rem <= 10'(OCT_SIZE)) ? rem : 10'(11'd1024 - {1'b0, rem});

    always_ff @(posedge i_clk) begin
        r_sin  <= SIN_TAB[rom_addr];
        r_cos  <= COS_TAB[rom_addr];
        r_quad <= i_req.phase[11:10];
        r_swap <= (rem > 10'(OCT_SIZE));
    end

    assign sv    = r_swap ? signed'({1'b0, r_cos}) : signed'({1'b0, r_sin});
    assign cv    = r_swap ? signed'({1'b0, r_sin}) : signed'({1'b0, r_cos});
    assign s_mag = r_quad[0] ? cv : sv;
    assign c_mag = r_quad[0] ? sv : cv;
    assign s_neg = r_quad[1] ^ ~i_inverse;
    assign c_neg = r_quad[1] ^ r_quad[0];

    always_ff @(posedge i_clk) begin
        r_c <= c_neg ? -c_mag : c_mag;
        r_s <= s_neg ? -s_mag : s_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_tw_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_req.valid;
            r_tw_valid <= r_rd_valid;
        end
    end

    assign o_rsp.valid = r_tw_valid;
    assign o_rsp.c     = r_c;
    assign o_rsp.s     = r_s;

endmodule

// File: src/ddbe_cmac.sv
// Shared complex multiply-accumulate unit.
module ddbe_cmac
    import ddbe_pkg::*;
#(
    parameter int MAX_POINTS_LOG2 = 8
)
(
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_clear,
    input  t_mac_in                                 i_in,
    output logic signed [MAX_POINTS_LOG2+48-1:0]    o_acc_re,
    output logic signed [MAX_POINTS_LOG2+48-1:0]    o_acc_im
);

    localparam int ACC_W = MAX_POINTS_LOG2 + 48;

    logic signed [47:0]      r_p_rc;
    logic signed [47:0]      r_p_is;
    logic signed [47:0]      r_p_rs;
    logic signed [47:0]      r_p_ic;
    logic                    r_p_valid;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;

    always_ff @(posedge i_clk) begin
        r_p_rc <= i_in.xr * i_in.c;
        r_p_is <= i_in.xi * i_in.s;
        r_p_rs <= i_in.xr * i_in.s;
        r_p_ic <= i_in.xi * i_in.c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_p_valid) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_rc) - ACC_W'(r_p_is);
            r_acc_im <= r_acc_im + ACC_W'(r_p_rs) + ACC_W'(r_p_ic);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

// File: src/ddbe_scale.sv
// Shared output scaler: magnitude, 1/sqrt2 step, rounding shift, saturation.
module ddbe_scale
    import ddbe_pkg::*;
#(
    parameter int MAX_POINTS_LOG2 = 8
)
(
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_scl_ctl                                i_ctl,
    input  logic signed [MAX_POINTS_LOG2+48-1:0]    i_acc,
    output t_scl_rsp                                o_rsp
);

    localparam int ACC_W = MAX_POINTS_LOG2 + 48;
    localparam int MAG_W = ACC_W - 1;
    localparam int HI_W  = MAG_W - 30;

    logic             use_c;
    logic [5:0]       sh1;
    logic [MAG_W-1:0] mag;
    logic [HI_W-1:0]  hi;
    logic [29:0]      lo;
    logic [MAG_W-1:0] v;

    logic [MAG_W-1:0] r0_m;
    logic             r0_neg;
    logic             r0_valid;
    logic [MAG_W-1:0] r1_phi;
    logic [59:0]      r1_plo;
    logic [MAG_W-1:0] r1_m;
    logic             r1_neg;
    logic             r1_valid;
    logic [MAG_W-1:0] r2_q;
    logic             r2_neg;
    logic             r2_valid;
    logic [MAG_W-1:0] r3_t;
    logic             r3_neg;
    logic             r3_valid;
    logic [15:0]      r4_value;
    logic             r4_sat;
    logic             r4_valid;

    assign use_c = !i_ctl.by_n && i_ctl.lg[0];
    assign sh1   = 6'd29 + (i_ctl.by_n ? {2'b00, i_ctl.lg} : {3'b000, i_ctl.lg[3:1]});
    assign mag   = i_acc[ACC_W-1] ? MAG_W'(-i_acc) : MAG_W'(i_acc);
    assign hi    = r0_m[MAG_W-1:30];
    assign lo    = r0_m[29:0];
    assign v     = (r3_t + MAG_W'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        r0_m   <= mag;
        r0_neg <= i_acc[ACC_W-1];
        r1_phi <= hi * INV_SQRT2_Q30;
        r1_plo <= lo * INV_SQRT2_Q30;
        r1_m   <= r0_m;
        r1_neg <= r0_neg;
        r2_q   <= use_c ? r1_phi + MAG_W'(r1_plo[59:30]) : r1_m;
        r2_neg <= r1_neg;
        r3_t   <= r2_q >> sh1;
        r3_neg <= r2_neg;
        if (r3_neg) begin
            if (v > MAG_W'(32'd32768)) begin
                r4_value <= 16'h8000;
                r4_sat   <= 1'b1;
            end else begin
                r4_value <= 16'd0 - v[15:0];
                r4_sat   <= 1'b0;
            end
        end else begin
            if (v > MAG_W'(32'd32767)) begin
                r4_value <= 16'h7fff;
                r4_sat   <= 1'b1;
            end else begin
                r4_value <= v[15:0];
                r4_sat   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r0_valid <= i_ctl.valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    assign o_rsp.valid = r4_valid;
    assign o_rsp.value = r4_value;
    assign o_rsp.sat   = r4_sat;

endmodule

// File: src/direct_dft_bin_engine_top.sv
// Top level of the direct DFT bin engine: sample store, sequencer and units.
// Write request: a new request may follow in the next cycle.
// Bin request: the sums run over m = min(samples_used, N) stored samples;
// the one complex multiply-accumulate unit walks one stored sample per cycle.
// Input is stalled from acceptance of a bin request until its result is registered.
// Synchronous reset restores the config registers; the sample store is not cleared.
module direct_dft_bin_engine_top
    import ddbe_pkg::*;
#(
    parameter int MAX_POINTS_LOG2 = 8
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_index,
    input  logic signed [15:0] i_sample_re,
    input  logic signed [15:0] i_sample_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_bin_re,
    output logic signed [15:0] o_bin_im,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);

    localparam int ADDR_W = MAX_POINTS_LOG2;
    localparam int DEPTH  = 1 << MAX_POINTS_LOG2;
    localparam int CNT_W  = (MAX_POINTS_LOG2 + 1 > 9) ? MAX_POINTS_LOG2 + 1 : 9;
    localparam int ACC_W  = MAX_POINTS_LOG2 + 48;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_SCALE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_smp;
    logic [31:0]       r_smp_d;

    logic              r_inverse;
    logic [3:0]        r_size_log2;
    logic              r_scale_by_n;
    logic [8:0]        r_samples_used;

    logic [3:0]        r_lg;
    logic [11:0]       r_step;
    logic [11:0]       r_phase;
    logic [ADDR_W-1:0] r_n;
    logic [ADDR_W-1:0] r_last;
    logic [1:0]        r_cnt;
    logic [1:0]        r_sc;
    logic              r_got;
    logic              r_o_valid;
    logic [15:0]       r_bin_re;
    logic [15:0]       r_bin_im;
    logic              r_sat_re;
    logic              r_sat;

    logic              in_acc;
    logic              bin_acc;
    logic [ADDR_W-1:0] wr_addr;
    logic [3:0]        lg_eff;
    logic [CNT_W-1:0]  n_pts;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  m_cnt;
    logic [11:0]       k_step;

    t_tw_req                 tw_req;
    t_tw_rsp                 tw_rsp;
    t_mac_in                 mac_in;
    t_scl_ctl                scl_ctl;
    t_scl_rsp                scl_rsp;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic signed [ACC_W-1:0] scl_acc;

    assign in_acc  = i_valid && !o_stall;
    assign bin_acc = in_acc && (i_opcode == OP_BIN);
    assign wr_addr = ADDR_W'(i_index);
    assign lg_eff  = (r_size_log2 > 4'(MAX_POINTS_LOG2)) ? 4'(MAX_POINTS_LOG2) : r_size_log2;
    assign n_pts   = CNT_W'(1) << lg_eff;
    assign used    = CNT_W'(r_samples_used);
    assign m_cnt   = (used > n_pts) ? n_pts : used;
    assign k_step  = 12'({12'd0, i_index} << (4'(TW_LOG2) - lg_eff));

    // sample store
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_opcode == OP_WRITE)) begin
            r_mem[wr_addr] <= {i_sample_re, i_sample_im};
        end
        r_smp   <= r_mem[r_n];
        r_smp_d <= r_smp;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (bin_acc) begin
                    n_state = (m_cnt == '0) ? S_DRAIN : S_RUN;
                end
            end
            S_RUN: begin
                if (r_n == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if ((r_cnt == '0) && !r_o_valid) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (scl_rsp.valid && r_got) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_inverse      <= 1'b0;
            r_size_log2    <= 4'd8;
            r_scale_by_n   <= 1'b0;
            r_samples_used <= 9'd256;
            r_cnt          <= '0;
            r_sc           <= '0;
            r_got          <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INVERSE:      r_inverse      <= i_cfg_data[0];
                    CFG_SIZE_LOG2:    r_size_log2    <= i_cfg_data[3:0];
                    CFG_SCALE_BY_N:   r_scale_by_n   <= i_cfg_data[0];
                    CFG_SAMPLES_USED: r_samples_used <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state != S_DRAIN) begin
                r_cnt <= 2'(PIPE_LAT - 1);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (r_state != S_SCALE) begin
                r_sc <= '0;
            end else if (!r_sc[1]) begin
                r_sc <= r_sc + 2'd1;
            end
            if (scl_rsp.valid) begin
                r_got <= !r_got;
            end
            if (scl_rsp.valid && r_got) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bin_acc) begin
            r_lg    <= lg_eff;
            r_step  <= k_step;
            r_phase <= '0;
            r_n     <= '0;
            r_last  <= ADDR_W'(m_cnt - CNT_W'(1));
        end else if (r_state == S_RUN) begin
            r_phase <= r_phase + r_step;
            r_n     <= r_n + ADDR_W'(1);
        end
        if (scl_rsp.valid) begin
            if (!r_got) begin
                r_bin_re <= scl_rsp.value;
                r_sat_re <= scl_rsp.sat;
            end else begin
                r_bin_im <= scl_rsp.value;
                r_sat    <= r_sat_re | scl_rsp.sat;
            end
        end
    end

    assign tw_req.valid = (r_state == S_RUN);
    assign tw_req.phase = r_phase;

    ddbe_twiddle u_twiddle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inverse (r_inverse),
        .i_req     (tw_req),
        .o_rsp     (tw_rsp)
    );

    assign mac_in.valid = tw_rsp.valid;
    assign mac_in.xr    = r_smp_d[31:16];
    assign mac_in.xi    = r_smp_d[15:0];
    assign mac_in.c     = tw_rsp.c;
    assign mac_in.s     = tw_rsp.s;

    ddbe_cmac #(
        .MAX_POINTS_LOG2 (MAX_POINTS_LOG2)
    ) u_cmac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (bin_acc),
        .i_in     (mac_in),
        .o_acc_re (acc_re),
        .o_acc_im (acc_im)
    );

    assign scl_ctl.valid = (r_state == S_SCALE) && !r_sc[1];
    assign scl_ctl.by_n  = r_scale_by_n;
    assign scl_ctl.lg    = r_lg;
    assign scl_acc       = r_sc[0] ? acc_im : acc_re;

    ddbe_scale #(
        .MAX_POINTS_LOG2 (MAX_POINTS_LOG2)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scl_ctl),
        .i_acc   (scl_acc),
        .o_rsp   (scl_rsp)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_bin_re    = r_bin_re;
    assign o_bin_im    = r_bin_im;
    assign o_saturated = r_sat;
    assign o_cfg_ready = 1'b1;

endmodule

// File: src/ddbe_sva.sv
// Port-level checker for the DFT bin engine, bound to the top level.
`include "direct_dft_bin_engine_top_defines.svh"

module ddbe_sva
    import ddbe_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_opcode,
    input logic [7:0]         i_index,
    input logic signed [15:0] i_sample_re,
    input logic signed [15:0] i_sample_im,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_bin_re,
    input logic signed [15:0] o_bin_im,
    input logic               o_saturated,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [2:0]         i_cfg_index,
    input logic [8:0]         i_cfg_data
);

    `DDBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_bin_re) && $stable(o_bin_im) && $stable(o_saturated), "result changed while stalled")
    `DDBE_ASSERT_NEXT(a_bin_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_opcode == OP_BIN), o_stall, "bin request did not occupy the engine")
    `DDBE_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, i_valid && !o_stall && (i_opcode == OP_WRITE), !o_stall, "write request blocked the next request")
    `DDBE_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result without a bin request in flight")

endmodule

bind direct_dft_bin_engine_top ddbe_sva u_ddbe_sva (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the direct DFT bin engine: sample writes, bin requests, registers.
`timescale 1ns / 100ps

module tb_top;
    import ddbe_pkg::*;

    localparam int MAX_LOG2     = 8;
    localparam int TW_BITS      = 12;
    localparam int OCT_LAST     = 512;
    localparam int QUARTER      = 1024;
    localparam int FRAC         = 30;
    localparam int IDLE_PCT     = 37;
    localparam int QUIET_FROM   = 2000;
    localparam int QUIET_TO     = 8000;
    localparam int SETTLE       = 280;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 55;

    localparam logic [2:0]  CFG_NONE  = 3'd7;
    localparam logic [63:0] PI_FX     = 64'd3373259426;
    localparam logic [63:0] ONE_FX    = 64'd1 << FRAC;
    localparam logic [63:0] RSQRT2_FX = 64'd759250125;

    typedef struct packed {
        logic        op;
        logic [7:0]  index;
        logic [15:0] re;
        logic [15:0] im;
    } t_req;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        sat;
    } t_bin;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic               i_opcode    = 1'b0;
    logic [7:0]         i_index     = '0;
    logic signed [15:0] i_sample_re = '0;
    logic signed [15:0] i_sample_im = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic signed [15:0] o_bin_re;
    logic signed [15:0] o_bin_im;
    logic               o_saturated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [8:0]         i_cfg_data  = '0;

    t_req req_q[$];
    t_bin bins_due[$];
    int   cycle_count = 0;
    int   fail_count  = 0;

    logic signed [15:0] store_re [0:255];
    logic signed [15:0] store_im [0:255];
    logic [63:0]        sin_oct [0:OCT_LAST];
    logic [63:0]        cos_oct [0:OCT_LAST];

    bit         cfg_inverse = 1'b0;
    logic [3:0] cfg_size_log2 = 4'd8;
    bit         cfg_by_n = 1'b0;
    logic [8:0] cfg_used = 9'd256;

    direct_dft_bin_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_index     (i_index),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** direct_dft_bin_engine_top: FAILED **");
            $finish;
        end
    end

    // Taylor series in Horner form; divisors are j*(j+1) walking down.
    function automatic void build_octant();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int u = 0; u <= OCT_LAST; u++) begin
            x  = (PI_FX * 64'(u) + 64'd1024) >> 11;
            x2 = (x * x) >> FRAC;
            t  = ONE_FX;
            for (int j = 10; j >= 2; j -= 2) begin
                t = ONE_FX - ((x2 * t) >> FRAC) / 64'(j * (j + 1));
            end
            sin_oct[u] = (x * t) >> FRAC;
            t = ONE_FX;
            for (int j = 11; j >= 1; j -= 2) begin
                t = ONE_FX - ((x2 * t) >> FRAC) / 64'(j * (j + 1));
            end
            cos_oct[u] = t;
        end
    endfunction

    function automatic void twiddle(input int unsigned angle, output longint c,
                                    output longint s);
        int unsigned a;
        int unsigned r;
        longint      sv;
        longint      cv;
        a = angle & ((1 << TW_BITS) - 1);
        r = a & (QUARTER - 1);
        if (r <= OCT_LAST) begin
            sv = longint'(sin_oct[r]);
            cv = longint'(cos_oct[r]);
        end else begin
            sv = longint'(cos_oct[QUARTER - r]);
            cv = longint'(sin_oct[QUARTER - r]);
        end
        case (a >> 10)
            0: begin s = sv;  c = cv;  end
            1: begin s = cv;  c = -sv; end
            2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    // Scale, round to nearest (ties away from zero) and clip one part.
    function automatic logic [15:0] scale_part(input longint acc, input int unsigned lg,
                                               inout bit sat);
        logic [63:0] mag;
        logic [63:0] v;
        int unsigned sh;
        mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        if (cfg_by_n) begin
            sh = FRAC + lg;
        end else begin
            sh = FRAC + lg / 2;
            if (lg[0]) begin
                mag = (mag >> FRAC) * RSQRT2_FX + (((mag & (ONE_FX - 1)) * RSQRT2_FX) >> FRAC);
            end
        end
        v = (mag + (64'd1 << (sh - 1))) >> sh;
        if (acc < 0) begin
            if (v > 64'd32768) begin
                v   = 64'd32768;
                sat = 1'b1;
            end
            return 16'(64'd65536 - v);
        end
        if (v > 64'd32767) begin
            v   = 64'd32767;
            sat = 1'b1;
        end
        return v[15:0];
    endfunction

    function automatic t_bin predict_bin(input logic [7:0] k_in);
        t_bin        res;
        int unsigned lg;
        int unsigned npts;
        int unsigned k;
        int unsigned m;
        int unsigned angle;
        longint      acc_re;
        longint      acc_im;
        longint      xr;
        longint      xi;
        longint      c;
        longint      s;
        bit          sat;
        lg     = (cfg_size_log2 > MAX_LOG2) ? MAX_LOG2 : cfg_size_log2;
        npts   = 1 << lg;
        k      = k_in & (npts - 1);
        m      = (cfg_used > npts) ? npts : cfg_used;
        acc_re = 0;
        acc_im = 0;
        sat    = 1'b0;
        for (int unsigned n = 0; n < m; n++) begin
            angle = ((k * n) & (npts - 1)) << (TW_BITS - lg);
            twiddle(angle, c, s);
            if (!cfg_inverse) s = -s;
            xr = store_re[n];
            xi = store_im[n];
            acc_re += xr * c - xi * s;
            acc_im += xr * s + xi * c;
        end
        res.re  = scale_part(acc_re, lg, sat);
        res.im  = scale_part(acc_im, lg, sat);
        res.sat = sat;
        return res;
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    always @(posedge i_clk) begin : drive
        t_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (i_opcode == OP_WRITE) begin
                    store_re[i_index] = i_sample_re;
                    store_im[i_index] = i_sample_im;
                end else begin
                    bins_due.push_back(predict_bin(i_index));
                end
            end
            if (!i_valid || !o_stall) begin
                if (req_q.size() != 0 && !idle_now()) begin
                    nxt = req_q.pop_front();
                    i_valid     <= 1'b1;
                    i_opcode    <= nxt.op;
                    i_index     <= nxt.index;
                    i_sample_re <= nxt.re;
                    i_sample_im <= nxt.im;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_bin want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (bins_due.size() == 0) begin
                    $error("unexpected bin: re %0d im %0d sat %0b",
                           o_bin_re, o_bin_im, o_saturated);
                    fail_count++;
                end else begin
                    want = bins_due.pop_front();
                    if (o_bin_re !== want.re) begin
                        $error("bin_re: expected %0d, got %0d", $signed(want.re), o_bin_re);
                        fail_count++;
                    end
                    if (o_bin_im !== want.im) begin
                        $error("bin_im: expected %0d, got %0d", $signed(want.im), o_bin_im);
                        fail_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $error("saturated: expected %0b, got %0b", want.sat, o_saturated);
                        fail_count++;
                    end
                end
            end
            i_stall <= idle_now();
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INVERSE:      cfg_inverse   = data[0];
            CFG_SIZE_LOG2:    cfg_size_log2 = data[3:0];
            CFG_SCALE_BY_N:   cfg_by_n      = data[0];
            CFG_SAMPLES_USED: cfg_used      = data;
            default: ;
        endcase
    endtask

    // Unused upper data bits are randomized; the block must ignore them.
    task automatic set_regs(input bit inv, input logic [3:0] lg, input bit by_n,
                            input logic [8:0] used);
        write_reg(CFG_INVERSE, {8'($urandom), inv});
        write_reg(CFG_SIZE_LOG2, {5'($urandom), lg});
        write_reg(CFG_SCALE_BY_N, {8'($urandom), by_n});
        write_reg(CFG_SAMPLES_USED, used);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_write(input logic [7:0] idx, input logic [15:0] re,
                               input logic [15:0] im);
        req_q.push_back('{op: OP_WRITE, index: idx, re: re, im: im});
    endtask

    task automatic queue_bin(input logic [7:0] k);
        req_q.push_back('{op: OP_BIN, index: k, re: 16'($urandom), im: 16'($urandom)});
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        do @(posedge i_clk); while (req_q.size() != 0 || i_valid || bins_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned order [0:255];
        int unsigned j;
        int unsigned tmp;
        int unsigned eff;
        int unsigned lg;
        int unsigned used;
        bit          inv;
        bit          by_n;

        build_octant();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_NONE, 9'h1FF);
        set_regs(1'b0, 4'd2, 1'b0, 9'd4);
        queue_write(8'd0, 16'h8000, 16'h8000);
        queue_write(8'd1, 16'h8000, 16'h8000);
        queue_write(8'd2, 16'h8000, 16'h7FFF);
        queue_write(8'd3, 16'h7FFF, 16'h8000);
        queue_write(8'd255, 16'h7FFF, 16'h7FFF);
        queue_bin(8'd0);
        queue_bin(8'd1);
        queue_bin(8'd2);
        queue_bin(8'd3);
        queue_bin(8'd255);
        drain();

        // single-point transform, nothing summed
        set_regs(1'b1, 4'd0, 1'b1, 9'd0);
        queue_bin(8'd7);
        queue_write(8'd4, 16'h1234, 16'hEDCB);
        drain();

        // odd size with the 1/sqrt(2) step, count clamped to N
        set_regs(1'b1, 4'd1, 1'b0, 9'd3);
        queue_bin(8'd0);
        queue_bin(8'd1);
        queue_bin(8'd254);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            inv  = $urandom_range(1);
            by_n = $urandom_range(1);
            lg   = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 5);
            case (p)
                0: begin lg = 15; inv = 1'b1; by_n = 1'b0; end
                1: begin lg = 0;  inv = 1'b0; by_n = 1'b0; end
                2: begin lg = 8;  by_n = 1'b1; end
                3: begin lg = 7;  by_n = 1'b0; end
                default: ;
            endcase
            eff = (lg > MAX_LOG2) ? MAX_LOG2 : lg;
            case ($urandom_range(3))
                0: used = 1 << eff;
                1: used = $urandom_range(511);
                2: used = $urandom_range(1 << eff);
                default: used = 511;
            endcase
            case (p)
                0: used = 511;
                1: used = 1;
                2: used = 256;
                default: ;
            endcase
            set_regs(inv, 4'(lg), by_n, 9'(used));
            if (p == 0) begin
                for (int i = 0; i < 256; i++) order[i] = i;
                for (int i = 255; i > 0; i--) begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < 256; i++) begin
                    queue_write(8'(order[i]), rand_sample(), rand_sample());
                end
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(1)) begin
                    queue_bin(8'($urandom));
                end else begin
                    queue_write(8'($urandom), rand_sample(), rand_sample());
                end
            end
            drain();
        end

        if (fail_count == 0 && bins_due.size() == 0) begin
            $display("** direct_dft_bin_engine_top: PASSED **");
        end else begin
            $display("** direct_dft_bin_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
